// File: design/pfr_pkg.sv
// Package for the paged frame replacement block: field widths, codes,
// and the structs passed between the register file, the core and the top.
// No dependencies.
package pfr_pkg;

   localparam int FRAMES_DEFAULT   = 4;
   localparam int PAGE_WORDS       = 256;
   localparam int INDEX_BITS       = 24;
   localparam int OFFSET_BITS      = $clog2(PAGE_WORDS);
   localparam int PAGE_BITS        = 16;
   localparam int FRAME_NUM_BITS   = 2;
   localparam int WORD_OFFSET_BITS = 8;
   localparam int STATUS_BITS      = 3;
   localparam int COUNT_BITS       = 32;
   localparam int ARRAY_WORDS_BITS = 25;
   localparam int SEED_BITS        = 16;
   localparam int PADDR_BITS       = 3;
   localparam int PDATA_BITS       = 32;

   localparam logic [SEED_BITS-1:0] SEED_DEFAULT = 16'd44257;

   typedef enum logic {
      OP_ACCESS = 1'b0,
      OP_FLUSH  = 1'b1
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_HIT   = 3'd0,
      ST_FAULT = 3'd1,
      ST_RANGE = 3'd2,
      ST_FLUSH = 3'd3,
      ST_EMPTY = 3'd4
   } status_type;

   typedef enum logic {
      REG_ARRAY_WORDS = 1'b0,
      REG_RANDOM_SEED = 1'b1
   } reg_type;

   typedef struct packed {
      logic                  step;
      op_type                opcode;
      logic [INDEX_BITS-1:0] word_index;
   } pfr_ctrl_type;

   typedef struct packed {
      logic                 load;
      logic [SEED_BITS-1:0] value;
   } pfr_seed_type;

   typedef struct packed {
      status_type                  status;
      logic [FRAME_NUM_BITS-1:0]   frame_number;
      logic [WORD_OFFSET_BITS-1:0] word_offset;
      logic [PAGE_BITS-1:0]        page_number;
      logic                        writeback_valid;
      logic [PAGE_BITS-1:0]        writeback_page;
      logic [COUNT_BITS-1:0]       hit_total;
      logic [COUNT_BITS-1:0]       fault_total;
      logic                        last;
   } pfr_result_type;

endpackage

// File: design/pfr_if.sv
// Channel interfaces for the request and response words.
// Depends on pfr_pkg.
interface pfr_req_if;
   import pfr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [INDEX_BITS-1:0] word_index;

   modport source (output valid, output opcode, output word_index, input ready);
   modport sink   (input valid, input opcode, input word_index, output ready);
endinterface

interface pfr_rsp_if;
   import pfr_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [STATUS_BITS-1:0]      status;
   logic [FRAME_NUM_BITS-1:0]   frame_number;
   logic [WORD_OFFSET_BITS-1:0] word_offset;
   logic [PAGE_BITS-1:0]        page_number;
   logic                        writeback_valid;
   logic [PAGE_BITS-1:0]        writeback_page;
   logic [COUNT_BITS-1:0]       hit_total;
   logic [COUNT_BITS-1:0]       fault_total;
   logic                        last;

   modport source (output valid, output status, output frame_number, output word_offset,
                   output page_number, output writeback_valid, output writeback_page,
                   output hit_total, output fault_total, output last, input ready);
   modport sink   (input valid, input status, input frame_number, input word_offset,
                   input page_number, input writeback_valid, input writeback_page,
                   input hit_total, input fault_total, input last, output ready);
endinterface

// File: design/pfr_csr.sv
// Configuration registers: array size and replacement seed, APB-style access.
// Depends on pfr_pkg.
module pfr_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [pfr_pkg::PADDR_BITS-1:0]        paddr,
   input  logic [pfr_pkg::PDATA_BITS-1:0]        pwdata,
   output logic [pfr_pkg::PDATA_BITS-1:0]        prdata,
   output logic                                  pready,
   output logic [pfr_pkg::ARRAY_WORDS_BITS-1:0]  array_words,
   output pfr_pkg::pfr_seed_type                 seed
);
   import pfr_pkg::*;

   logic [ARRAY_WORDS_BITS-1:0] array_words_ff, array_words_in;
   logic [SEED_BITS-1:0]        seed_ff, seed_in;
   logic                        wr_en;
   reg_type                     sel_reg;

   // Low address bits are not decoded.
   assign sel_reg = reg_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      array_words_in = array_words_ff;
      seed_in        = seed_ff;
      if (wr_en) begin
         case (sel_reg)
            REG_ARRAY_WORDS: array_words_in = pwdata[ARRAY_WORDS_BITS-1:0];
            REG_RANDOM_SEED: seed_in        = pwdata[SEED_BITS-1:0];
            default:         array_words_in = array_words_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         array_words_ff <= '0;
         seed_ff        <= SEED_DEFAULT;
      end else begin
         array_words_ff <= array_words_in;
         seed_ff        <= seed_in;
      end
   end

   always_comb begin
      case (sel_reg)
         REG_ARRAY_WORDS: prdata = PDATA_BITS'(array_words_ff);
         REG_RANDOM_SEED: prdata = PDATA_BITS'(seed_ff);
         default:         prdata = '0;
      endcase
   end

   assign array_words = array_words_ff;
   assign seed.load   = wr_en && (sel_reg == REG_RANDOM_SEED);
   assign seed.value  = pwdata[SEED_BITS-1:0];

endmodule

// File: design/pfr_core.sv
// Frame table, tag lookup, replacement LFSR and hit/fault counters.
// Builds one result word per step. Depends on pfr_pkg.
module pfr_core #(
   parameter int FRAMES = pfr_pkg::FRAMES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pfr_pkg::pfr_ctrl_type                 ctrl,
   input  logic [FRAMES-1:0]                     done_mask,
   input  logic [pfr_pkg::ARRAY_WORDS_BITS-1:0]  array_words,
   input  pfr_pkg::pfr_seed_type                 seed,
   output pfr_pkg::pfr_result_type               result,
   output logic [FRAMES-1:0]                     flush_pick
);
   import pfr_pkg::*;

   localparam int  FRAME_BITS  = $clog2(FRAMES);
   localparam int  RECIP_SHIFT = 20;
   localparam int  RECIP       = (1 << RECIP_SHIFT) / FRAMES;
   localparam bit  FRAMES_POW2 = ((FRAMES & (FRAMES - 1)) == 0);
   localparam int  PROD_BITS   = SEED_BITS + RECIP_SHIFT + 1;

   logic [PAGE_BITS-1:0]   tag_ff [FRAMES];
   logic [FRAMES-1:0]      occ_ff, occ_in;
   logic [SEED_BITS-1:0]   lfsr_ff, lfsr_in;
   logic [COUNT_BITS-1:0]  hit_ff, hit_in;
   logic [COUNT_BITS-1:0]  fault_ff, fault_in;

   logic [OFFSET_BITS-1:0] offset;
   logic [PAGE_BITS-1:0]   page;
   logic                   in_range;
   logic                   hit_any, empty_any;
   logic [FRAME_BITS-1:0]  hit_frame, empty_frame, victim, fill_frame;
   logic [SEED_BITS-1:0]   lfsr_nxt;
   logic [PROD_BITS-1:0]   recip_prod;
   logic [SEED_BITS-1:0]   quot;
   logic [PROD_BITS-1:0]   remain;
   logic [FRAMES-1:0]      cand;
   logic [FRAME_BITS-1:0]  pick_frame;
   logic                   do_hit, do_fault, tag_wr;

   assign offset   = ctrl.word_index[OFFSET_BITS-1:0];
   assign page     = PAGE_BITS'(ctrl.word_index >> OFFSET_BITS);
   assign in_range = {1'b0, ctrl.word_index} < array_words;

   // Lowest matching frame and lowest empty frame.
   always_comb begin
      hit_any     = 1'b0;
      hit_frame   = '0;
      empty_any   = 1'b0;
      empty_frame = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (occ_ff[i] && (tag_ff[i] == page)) begin
            hit_any   = 1'b1;
            hit_frame = FRAME_BITS'(i);
         end
         if (!occ_ff[i]) begin
            empty_any   = 1'b1;
            empty_frame = FRAME_BITS'(i);
         end
      end
   end

   // Fibonacci LFSR, taps 16,14,13,11; victim is the stepped value modulo FRAMES,
   // taken by reciprocal multiply and one correction.
   always_comb begin
      lfsr_nxt   = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[SEED_BITS-1:1]};
      recip_prod = PROD_BITS'(lfsr_nxt) * PROD_BITS'(RECIP);
      quot       = SEED_BITS'(recip_prod >> RECIP_SHIFT);
      remain     = PROD_BITS'(lfsr_nxt) - PROD_BITS'(quot) * PROD_BITS'(FRAMES);
      if (remain >= PROD_BITS'(FRAMES)) begin
         remain = remain - PROD_BITS'(FRAMES);
      end
      if (FRAMES_POW2) begin
         victim = lfsr_nxt[FRAME_BITS-1:0];
      end else begin
         victim = remain[FRAME_BITS-1:0];
      end
   end

   assign fill_frame = empty_any ? empty_frame : victim;

   // Flush walks the occupied frames not yet reported, lowest first.
   assign cand = occ_ff & ~done_mask;
   always_comb begin
      pick_frame = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pick_frame = FRAME_BITS'(i);
         end
      end
   end
   assign flush_pick = FRAMES'(1) << pick_frame;

   assign do_hit   = ctrl.step && (ctrl.opcode == OP_ACCESS) && in_range && hit_any;
   assign do_fault = ctrl.step && (ctrl.opcode == OP_ACCESS) && in_range && !hit_any;
   assign tag_wr   = do_fault;

   always_comb begin
      occ_in   = occ_ff;
      lfsr_in  = lfsr_ff;
      hit_in   = hit_ff + COUNT_BITS'(do_hit);
      fault_in = fault_ff + COUNT_BITS'(do_fault);
      if (do_fault) begin
         occ_in[fill_frame] = 1'b1;
         if (!empty_any) begin
            lfsr_in = lfsr_nxt;
         end
      end
      if (seed.load) begin
         lfsr_in = (seed.value == '0) ? SEED_BITS'(1) : seed.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         lfsr_ff  <= SEED_DEFAULT;
         hit_ff   <= '0;
         fault_ff <= '0;
      end else begin
         occ_ff   <= occ_in;
         lfsr_ff  <= lfsr_in;
         hit_ff   <= hit_in;
         fault_ff <= fault_in;
      end
   end

   // Tags are only read where the frame is occupied, so they need no reset.
   always_ff @(posedge clock) begin
      if (tag_wr) begin
         tag_ff[fill_frame] <= page;
      end
   end

   always_comb begin
      result.status          = ST_HIT;
      result.frame_number    = '0;
      result.word_offset     = WORD_OFFSET_BITS'(offset);
      result.page_number     = page;
      result.writeback_valid = 1'b0;
      result.writeback_page  = '0;
      result.hit_total       = hit_in;
      result.fault_total     = fault_in;
      result.last            = 1'b1;
      case (ctrl.opcode)
         OP_FLUSH: begin
            result.word_offset = '0;
            if (occ_ff == '0) begin
               result.status      = ST_EMPTY;
               result.page_number = '0;
            end else begin
               result.status          = ST_FLUSH;
               result.frame_number    = FRAME_NUM_BITS'(pick_frame);
               result.page_number     = tag_ff[pick_frame];
               result.writeback_valid = 1'b1;
               result.writeback_page  = tag_ff[pick_frame];
               result.last            = ((cand & ~flush_pick) == '0);
            end
         end
         OP_ACCESS: begin
            if (!in_range) begin
               result.status = ST_RANGE;
            end else if (hit_any) begin
               result.status       = ST_HIT;
               result.frame_number = FRAME_NUM_BITS'(hit_frame);
            end else begin
               result.status          = ST_FAULT;
               result.frame_number    = FRAME_NUM_BITS'(fill_frame);
               result.writeback_valid = occ_ff[fill_frame];
               result.writeback_page  = occ_ff[fill_frame] ? tag_ff[fill_frame] : '0;
            end
         end
         default: result.status = ST_HIT;
      endcase
   end

endmodule

// File: design/paged_frame_replacement_top.sv
// Top level of the paged frame replacement block: input register, flush walk, result
// register and channel ports. Depends on pfr_pkg, pfr_if, pfr_csr and pfr_core.
// Throughput: one access word per cycle while the result register is not stalled; a
// flush holds the input register until it has given one result word per occupied frame
// (one if none), one result word per cycle from the result register.
// Reset empties all frames, clears both counters, zeroes array_words and loads the seed.
module paged_frame_replacement_top #(
   parameter int FRAMES = pfr_pkg::FRAMES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   pfr_req_if.sink                          req_chan,
   pfr_rsp_if.source                        rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pfr_pkg::PADDR_BITS-1:0]   paddr,
   input  logic [pfr_pkg::PDATA_BITS-1:0]   pwdata,
   output logic [pfr_pkg::PDATA_BITS-1:0]   prdata,
   output logic                             pready
);
   import pfr_pkg::*;

   logic                        s1_valid_ff, s1_valid_in;
   op_type                      s1_op_ff;
   logic [INDEX_BITS-1:0]       s1_index_ff;
   logic [FRAMES-1:0]           done_ff, done_in;
   logic                        out_valid_ff, out_valid_in;
   pfr_result_type              out_ff;

   logic [ARRAY_WORDS_BITS-1:0] array_words;
   pfr_seed_type                seed;
   pfr_ctrl_type                ctrl;
   pfr_result_type              core_res;
   logic [FRAMES-1:0]           flush_pick;
   logic                        out_free, step, finish, req_fire;

   pfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .array_words (array_words),
      .seed        (seed)
   );

   pfr_core #(.FRAMES(FRAMES)) u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .done_mask   (done_ff),
      .array_words (array_words),
      .seed        (seed),
      .result      (core_res),
      .flush_pick  (flush_pick)
   );

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step     = s1_valid_ff && out_free;
   assign finish   = step && core_res.last;
   assign req_chan.ready = !s1_valid_ff || finish;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign ctrl.step       = step;
   assign ctrl.opcode     = s1_op_ff;
   assign ctrl.word_index = s1_index_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      done_in     = done_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         done_in     = '0;
      end else begin
         if (finish) begin
            s1_valid_in = 1'b0;
         end
         if (step && (s1_op_ff == OP_FLUSH)) begin
            done_in = done_ff | flush_pick;
         end
      end
      out_valid_in = step || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= op_type'(req_chan.opcode);
         s1_index_ff <= req_chan.word_index;
      end
      if (step) begin
         out_ff <= core_res;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.status          = out_ff.status;
   assign rsp_chan.frame_number    = out_ff.frame_number;
   assign rsp_chan.word_offset     = out_ff.word_offset;
   assign rsp_chan.page_number     = out_ff.page_number;
   assign rsp_chan.writeback_valid = out_ff.writeback_valid;
   assign rsp_chan.writeback_page  = out_ff.writeback_page;
   assign rsp_chan.hit_total       = out_ff.hit_total;
   assign rsp_chan.fault_total     = out_ff.fault_total;
   assign rsp_chan.last            = out_ff.last;

   // A flush entry always names one frame that has not been reported yet.
   assert property (@(posedge clock) disable iff (reset)
      (step && (core_res.status == ST_FLUSH)) |->
         ($onehot(flush_pick) && ((flush_pick & done_ff) == '0)))
      else $error("flush picked a frame twice");

   // Each non-final flush word marks exactly one more frame as reported.
   assert property (@(posedge clock) disable iff (reset)
      (step && (s1_op_ff == OP_FLUSH) && !core_res.last) |=>
         ($countones(done_ff) == $past($countones(done_ff)) + 1))
      else $error("flush walk did not advance by one frame");

   // Only faults and flush entries ask for a write-back.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.writeback_valid) |->
         ((out_ff.status == ST_FAULT) || (out_ff.status == ST_FLUSH)))
      else $error("write-back flagged on a word that cannot evict");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for paged_frame_replacement_top: request words go in, result words
// are checked field by field against a frame-table predictor. Depends on pfr_pkg, pfr_if
// and the design files.
module testbench;
   import pfr_pkg::*;

   localparam int FRAMES        = FRAMES_DEFAULT;
   localparam int RANDOM_WORDS  = 137;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_PRINTS    = 60;
   // About 430 words of up to 4 results each, every result stalled by a busy receiver
   // and every word by a busy sender, stay well inside this limit.
   localparam int CYCLE_LIMIT   = 300000;

   typedef struct packed {
      op_type                opcode;
      logic [INDEX_BITS-1:0] word_index;
   } frame_request_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [PADDR_BITS-1:0] paddr;
   logic [PDATA_BITS-1:0] pwdata;
   logic [PDATA_BITS-1:0] prdata;
   logic pready;

   pfr_req_if req_if ();
   pfr_rsp_if rsp_if ();

   paged_frame_replacement_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Predicted state of the frame table.
   logic [PAGE_BITS-1:0]        frame_page [0:FRAMES-1];
   logic                        frame_used [0:FRAMES-1];
   logic [SEED_BITS-1:0]        victim_lfsr;
   logic [COUNT_BITS-1:0]       hit_count;
   logic [COUNT_BITS-1:0]       fault_count;
   logic [ARRAY_WORDS_BITS-1:0] words_limit;

   frame_request_type pending_words [$];
   pfr_result_type    expected_results [$];
   logic [PAGE_BITS-1:0] hot_pages [0:5];

   int snd_idle_pct;
   int rcv_idle_pct;
   bit hold_request;
   int hold_left;
   int queued_words;
   int accepted_words;
   int results_checked;
   int evictions;
   int csr_writes;
   int error_count;
   int cycle_count;
   int status_seen [0:7];

   initial clock = 1'b0;
   always #6 clock = ~clock;

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic pfr_result_type make_result(status_type st, int frame,
                                                   logic [WORD_OFFSET_BITS-1:0] offset,
                                                   logic [PAGE_BITS-1:0] page, logic wb_valid,
                                                   logic [PAGE_BITS-1:0] wb_page, logic is_last);
      pfr_result_type res;
      res.status          = st;
      res.frame_number    = FRAME_NUM_BITS'(frame);
      res.word_offset     = offset;
      res.page_number     = page;
      res.writeback_valid = wb_valid;
      res.writeback_page  = wb_page;
      res.hit_total       = hit_count;
      res.fault_total     = fault_count;
      res.last            = is_last;
      return res;
   endfunction

   // Works out the result words of one accepted request word and updates the frame table.
   task automatic predict_frames(op_type op, logic [INDEX_BITS-1:0] index);
      logic [PAGE_BITS-1:0]        page;
      logic [WORD_OFFSET_BITS-1:0] offset;
      logic                        evicting;
      logic [PAGE_BITS-1:0]        victim_page;
      logic                        feedback;
      int slot;
      int last_slot;
      page   = PAGE_BITS'(index >> OFFSET_BITS);
      offset = index[OFFSET_BITS-1:0];
      if (op == OP_FLUSH) begin
         last_slot = -1;
         for (int i = 0; i < FRAMES; i++)
            if (frame_used[i]) last_slot = i;
         if (last_slot < 0) begin
            expected_results.push_back(make_result(ST_EMPTY, 0, '0, '0, 1'b0, '0, 1'b1));
         end else begin
            for (int i = 0; i < FRAMES; i++)
               if (frame_used[i])
                  expected_results.push_back(make_result(ST_FLUSH, i, '0, frame_page[i], 1'b1,
                                                         frame_page[i], i == last_slot));
         end
      end else if ({1'b0, index} >= words_limit) begin
         expected_results.push_back(make_result(ST_RANGE, 0, offset, page, 1'b0, '0, 1'b1));
      end else begin
         slot = -1;
         for (int i = 0; i < FRAMES; i++)
            if (frame_used[i] && frame_page[i] == page) slot = i;
         if (slot >= 0) begin
            hit_count++;
            expected_results.push_back(make_result(ST_HIT, slot, offset, page, 1'b0, '0, 1'b1));
         end else begin
            for (int i = FRAMES - 1; i >= 0; i--)
               if (!frame_used[i]) slot = i;
            // The LFSR only moves when every frame is taken.
            if (slot < 0) begin
               feedback    = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
               victim_lfsr = {feedback, victim_lfsr[SEED_BITS-1:1]};
               slot        = victim_lfsr % FRAMES;
            end
            evicting    = frame_used[slot];
            victim_page = evicting ? frame_page[slot] : '0;
            frame_page[slot] = page;
            frame_used[slot] = 1'b1;
            fault_count++;
            expected_results.push_back(make_result(ST_FAULT, slot, offset, page, evicting,
                                                   victim_page, 1'b1));
         end
      end
   endtask

   // Write a register, mirror it in the predictor, then read it back.
   task automatic write_csr(reg_type which, logic [PDATA_BITS-1:0] value);
      logic [PDATA_BITS-1:0] stored;
      stored = (which == REG_ARRAY_WORDS) ? (value & 32'h01FF_FFFF) : (value & 32'h0000_FFFF);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (which == REG_ARRAY_WORDS) begin
         words_limit = stored[ARRAY_WORDS_BITS-1:0];
      end else begin
         victim_lfsr = (stored[SEED_BITS-1:0] == '0) ? SEED_BITS'(1) : stored[SEED_BITS-1:0];
      end
      csr_writes++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== stored)
         report_error($sformatf("register %s reads %0h, written %0h", which.name(), prdata,
                                stored));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic queue_access(logic [INDEX_BITS-1:0] index);
      frame_request_type item;
      item.opcode     = OP_ACCESS;
      item.word_index = index;
      pending_words.push_back(item);
      queued_words++;
   endtask

   task automatic queue_flush();
      frame_request_type item;
      item.opcode     = OP_FLUSH;
      item.word_index = INDEX_BITS'($urandom);
      pending_words.push_back(item);
      queued_words++;
   endtask

   // Mostly pages from a small working set so that hits and evictions are common.
   task automatic queue_random();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8)
         queue_flush();
      else if (pick < 78)
         queue_access({hot_pages[$urandom_range(5)], WORD_OFFSET_BITS'($urandom)});
      else
         queue_access(INDEX_BITS'($urandom));
   endtask

   // Returns once every queued word is in and every result word is out.
   task automatic wait_idle();
      while (accepted_words != queued_words || expected_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got %0h, expected %0h", results_checked, name,
                                got, want));
   endtask

   task automatic check_result();
      pfr_result_type want;
      if (expected_results.size() == 0) begin
         report_error("result word arrived with nothing expected");
         return;
      end
      want = expected_results.pop_front();
      compare_field("status", 32'(rsp_if.status), 32'(want.status));
      compare_field("frame_number", 32'(rsp_if.frame_number), 32'(want.frame_number));
      compare_field("word_offset", 32'(rsp_if.word_offset), 32'(want.word_offset));
      compare_field("page_number", 32'(rsp_if.page_number), 32'(want.page_number));
      compare_field("writeback_valid", 32'(rsp_if.writeback_valid),
                    32'(want.writeback_valid));
      compare_field("writeback_page", 32'(rsp_if.writeback_page), 32'(want.writeback_page));
      compare_field("hit_total", rsp_if.hit_total, want.hit_total);
      compare_field("fault_total", rsp_if.fault_total, want.fault_total);
      compare_field("last", 32'(rsp_if.last), 32'(want.last));
      status_seen[want.status]++;
      if (want.status == ST_FAULT && want.writeback_valid) evictions++;
      results_checked++;
   endtask

   always @(posedge clock) begin : request_driver
      frame_request_type next_word;
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.opcode     <= 1'b0;
         req_if.word_index <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_frames(op_type'(req_if.opcode), req_if.word_index);
            accepted_words++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               next_word = pending_words.pop_front();
               req_if.valid      <= 1'b1;
               req_if.opcode     <= next_word.opcode;
               req_if.word_index <= next_word.word_index;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_result();
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ERROR: no completion within %0d cycles", CYCLE_LIMIT);
      $display("paged_frame_replacement_top test failed");
      $finish;
   end

   initial begin : stimulus
      logic [ARRAY_WORDS_BITS-1:0] phase_words;
      int base_words;
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      hold_request      = 1'b0;
      hold_left         = 0;
      queued_words      = 0;
      accepted_words    = 0;
      results_checked   = 0;
      evictions         = 0;
      csr_writes        = 0;
      error_count       = 0;
      for (int i = 0; i < 8; i++) status_seen[i] = 0;
      for (int i = 0; i < FRAMES; i++) begin
         frame_page[i] = '0;
         frame_used[i] = 1'b0;
      end
      victim_lfsr  = SEED_DEFAULT;
      hit_count    = '0;
      fault_count  = '0;
      words_limit  = '0;
      snd_idle_pct = 31;
      rcv_idle_pct = 71;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Out of reset the array is empty, so every access is out of range.
      queue_access('0);
      queue_access('1);
      queue_flush();
      wait_idle();

      write_csr(REG_ARRAY_WORDS, 32'h0100_0000);
      write_csr(REG_RANDOM_SEED, 32'd1);
      queue_access(24'h000000);
      queue_access(24'hFFFFFF);
      queue_access(24'h0000FF);
      queue_access(24'h000105);
      queue_flush();
      queue_access(24'h5A5A5A);
      queue_access(24'hA5A5A5);
      queue_access(24'hFFFF00);
      queue_flush();
      queue_access(24'h800000);
      queue_flush();
      wait_idle();

      // A zero seed must behave as a seed of one.
      write_csr(REG_ARRAY_WORDS, 32'd300);
      write_csr(REG_RANDOM_SEED, 32'd0);
      queue_access(24'd299);
      queue_access(24'd300);
      queue_access(24'hFFFFFF);
      queue_access(24'h000100);
      queue_flush();
      wait_idle();

      for (int phase = 0; phase < 3; phase++) begin
         for (int i = 0; i < 6; i++) hot_pages[i] = PAGE_BITS'($urandom);
         case (phase)
            0: begin
               snd_idle_pct = 31;
               rcv_idle_pct = 71;
               write_csr(REG_ARRAY_WORDS, 32'h0100_0000);
               write_csr(REG_RANDOM_SEED, 32'h0000_FFFF);
            end
            1: begin
               snd_idle_pct = 71;
               rcv_idle_pct = 31;
               phase_words  = ARRAY_WORDS_BITS'($urandom_range(1024, 24'hFFFFFF));
               // Spread the working set up to the last page, which may be only partly in range.
               for (int i = 0; i < 6; i++)
                  hot_pages[i] = PAGE_BITS'($urandom_range(0, phase_words >> OFFSET_BITS));
               write_csr(REG_ARRAY_WORDS, 32'(phase_words));
               write_csr(REG_RANDOM_SEED, 32'($urandom_range(1, 65535)));
            end
            default: begin
               snd_idle_pct = 0;
               rcv_idle_pct = 0;
               hot_pages[0] = '1;
               write_csr(REG_ARRAY_WORDS, 32'h00FF_FFFF);
               write_csr(REG_RANDOM_SEED, 32'($urandom_range(1, 65535)));
            end
         endcase
         base_words = accepted_words;
         repeat (RANDOM_WORDS) queue_random();
         if (phase == 0) begin
            // A long receiver stall while the sender keeps offering backs the block up.
            while (accepted_words < base_words + 40) @(posedge clock);
            hold_request = 1'b1;
         end
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_error($sformatf("%0d expected result words never arrived",
                                expected_results.size()));
      $display("Checked %0d result words from %0d request words: %0d hits, %0d faults",
               results_checked, accepted_words, status_seen[ST_HIT], status_seen[ST_FAULT]);
      $display("  (%0d evictions), %0d out of range, %0d flush entries, %0d empty flushes,",
               evictions, status_seen[ST_RANGE], status_seen[ST_FLUSH],
               status_seen[ST_EMPTY]);
      $display("  %0d register writes", csr_writes);
      if (error_count == 0) begin
         $display("paged_frame_replacement_top test passed");
      end else begin
         $display("paged_frame_replacement_top test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/pfr_pkg.sv
design/pfr_if.sv
design/pfr_csr.sv
design/pfr_core.sv
design/paged_frame_replacement_top.sv
bench/testbench.sv
